>>> rtl/rwl_pkg.sv
// shared types and codes for the reader-writer lock arbiter
`default_nettype none

package rwl_pkg;

	localparam int unsigned TYPE_W = 3;
	localparam int unsigned ID_W   = 8;
	localparam int unsigned RT_W   = 64;
	localparam int unsigned CODE_W = 2;
	localparam int unsigned CNT_W  = 8;

	// request codes
	localparam logic [TYPE_W-1:0] REQ_ACQ_EXCL = 3'd0;
	localparam logic [TYPE_W-1:0] REQ_ACQ_SH   = 3'd1;
	localparam logic [TYPE_W-1:0] REQ_TRY_EXCL = 3'd2;
	localparam logic [TYPE_W-1:0] REQ_TRY_SH   = 3'd3;
	localparam logic [TYPE_W-1:0] REQ_REL_EXCL = 3'd4;
	localparam logic [TYPE_W-1:0] REQ_REL_SH   = 3'd5;

	// status codes
	localparam logic [CODE_W-1:0] ST_GRANT    = 2'd0;
	localparam logic [CODE_W-1:0] ST_WAIT     = 2'd1;
	localparam logic [CODE_W-1:0] ST_RELEASED = 2'd2;
	localparam logic [CODE_W-1:0] ST_ERROR    = 2'd3;

	// wake codes
	localparam logic [CODE_W-1:0] WAKE_NONE = 2'd0;
	localparam logic [CODE_W-1:0] WAKE_ONE  = 2'd1;
	localparam logic [CODE_W-1:0] WAKE_ALL  = 2'd2;

	typedef enum logic [1:0] {
		MODE_FREE    = 2'd0,
		MODE_SHARED  = 2'd1,
		MODE_EXCL    = 2'd2,
		MODE_UPGRADE = 2'd3
	} lock_mode_t;

	typedef struct packed {
		logic [TYPE_W-1:0] req_type;
		logic [ID_W-1:0]   requester_id;
		logic [RT_W-1:0]   requester_runtime;
	} req_t;

	typedef struct packed {
		logic [CODE_W-1:0] status;
		logic [CODE_W-1:0] wake_kind;
		logic [ID_W-1:0]   wake_id;
		logic [CODE_W-1:0] lock_state_now;
		logic [CNT_W-1:0]  sharers_now;
	} rsp_t;

endpackage

`default_nettype wire

>>> rtl/rwl_req_if.sv
// request channel: valid/ready with request payload
`default_nettype none

interface rwl_req_if;
	logic                          valid;
	logic                          ready;
	logic [rwl_pkg::TYPE_W-1:0]    req_type;
	logic [rwl_pkg::ID_W-1:0]      requester_id;
	logic [rwl_pkg::RT_W-1:0]      requester_runtime;

	modport source (output valid, req_type, requester_id, requester_runtime, input ready);
	modport sink (input valid, req_type, requester_id, requester_runtime, output ready);
endinterface

`default_nettype wire

>>> rtl/rwl_rsp_if.sv
// response channel: valid/ready with result payload
`default_nettype none

interface rwl_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [rwl_pkg::CODE_W-1:0]    status;
	logic [rwl_pkg::CODE_W-1:0]    wake_kind;
	logic [rwl_pkg::ID_W-1:0]      wake_id;
	logic [rwl_pkg::CODE_W-1:0]    lock_state_now;
	logic [rwl_pkg::CNT_W-1:0]     sharers_now;

	modport source (output valid, status, wake_kind, wake_id, lock_state_now, sharers_now,
		input ready);
	modport sink (input valid, status, wake_kind, wake_id, lock_state_now, sharers_now,
		output ready);
endinterface

`default_nettype wire

>>> rtl/rwl_req_reg.sv
// input stage register for lock requests
`default_nettype none

module rwl_req_reg (
	input  wire logic          clk,
	input  wire logic          arst_n,
	rwl_req_if.sink            req,
	input  wire logic          advance,
	output rwl_pkg::req_t      req_s1,
	output logic               valid_s1
);

	rwl_pkg::req_t req_data_s1;
	logic          req_valid_s1;

	assign req.ready = !req_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (req.ready) begin
			req_valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_data_s1.req_type          <= req.req_type;
			req_data_s1.requester_id      <= req.requester_id;
			req_data_s1.requester_runtime <= req.requester_runtime;
		end
	end

	assign req_s1   = req_data_s1;
	assign valid_s1 = req_valid_s1;

endmodule

`default_nettype wire

>>> rtl/rwl_lock_core.sv
// lock state registers and per-request decision logic
`default_nettype none

module rwl_lock_core #(
	parameter int unsigned ID_BITS     = 8,
	parameter int unsigned MAX_SHARERS = 255
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire rwl_pkg::req_t req,
	input  wire logic          fire,
	output rwl_pkg::rsp_t      rsp
);

	localparam int unsigned CW = (MAX_SHARERS < 2) ? 1 : $clog2(MAX_SHARERS + 1);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SHARERS);
	localparam logic [CW-1:0] ONE_CNT = CW'(1);
	localparam logic [rwl_pkg::ID_W-1:0] ID_MASK = (ID_BITS >= rwl_pkg::ID_W) ?
		{rwl_pkg::ID_W{1'b1}} : rwl_pkg::ID_W'((1 << ID_BITS) - 1);

	rwl_pkg::lock_mode_t           mode_q, mode_d;
	logic [CW-1:0]                 cnt_q, cnt_d;
	logic [rwl_pkg::ID_W-1:0]      hid_q, hid_d;
	logic [rwl_pkg::RT_W-1:0]      hrt_q, hrt_d;
	logic [rwl_pkg::ID_W-1:0]      id;
	logic [rwl_pkg::RT_W-1:0]      rt;
	logic [CW+rwl_pkg::CNT_W-1:0]  cnt_ext;

	assign id = req.requester_id & ID_MASK;
	assign rt = req.requester_runtime;

	always_comb begin
		mode_d = mode_q;
		cnt_d  = cnt_q;
		hid_d  = hid_q;
		hrt_d  = hrt_q;
		rsp.status    = rwl_pkg::ST_ERROR;
		rsp.wake_kind = rwl_pkg::WAKE_NONE;
		rsp.wake_id   = '0;
		case (req.req_type)
			rwl_pkg::REQ_ACQ_EXCL: begin
				if (mode_q == rwl_pkg::MODE_FREE) begin
					mode_d = rwl_pkg::MODE_EXCL;
					hid_d  = id;
					hrt_d  = rt;
					rsp.status = rwl_pkg::ST_GRANT;
				end else begin
					// record the upgrader, lowest runtime wins
					if (mode_q == rwl_pkg::MODE_SHARED) begin
						mode_d = rwl_pkg::MODE_UPGRADE;
						hid_d  = id;
						hrt_d  = rt;
					end else if (mode_q == rwl_pkg::MODE_UPGRADE && rt < hrt_q) begin
						hid_d = id;
						hrt_d = rt;
					end
					rsp.status = rwl_pkg::ST_WAIT;
				end
			end
			rwl_pkg::REQ_TRY_EXCL: begin
				if (mode_q == rwl_pkg::MODE_FREE) begin
					mode_d = rwl_pkg::MODE_EXCL;
					hid_d  = id;
					hrt_d  = rt;
					rsp.status = rwl_pkg::ST_GRANT;
				end else begin
					rsp.status = rwl_pkg::ST_WAIT;
				end
			end
			rwl_pkg::REQ_ACQ_SH, rwl_pkg::REQ_TRY_SH: begin
				if (mode_q == rwl_pkg::MODE_EXCL) begin
					rsp.status = rwl_pkg::ST_WAIT;
				end else if (mode_q == rwl_pkg::MODE_UPGRADE && rt > hrt_q) begin
					rsp.status = rwl_pkg::ST_WAIT;
				end else if (cnt_q >= MAX_CNT) begin
					rsp.status = rwl_pkg::ST_ERROR;
				end else begin
					cnt_d = cnt_q + ONE_CNT;
					if (mode_q != rwl_pkg::MODE_UPGRADE) begin
						mode_d = rwl_pkg::MODE_SHARED;
					end
					rsp.status = rwl_pkg::ST_GRANT;
				end
			end
			rwl_pkg::REQ_REL_EXCL: begin
				if (mode_q == rwl_pkg::MODE_EXCL && hid_q == id) begin
					mode_d = rwl_pkg::MODE_FREE;
					hid_d  = '0;
					hrt_d  = '0;
					rsp.status    = rwl_pkg::ST_RELEASED;
					rsp.wake_kind = rwl_pkg::WAKE_ALL;
				end
			end
			rwl_pkg::REQ_REL_SH: begin
				if (cnt_q != '0 &&
					(mode_q == rwl_pkg::MODE_SHARED || mode_q == rwl_pkg::MODE_UPGRADE)) begin
					cnt_d = cnt_q - ONE_CNT;
					rsp.status = rwl_pkg::ST_RELEASED;
					// last sharer out frees the lock
					if (cnt_q == ONE_CNT) begin
						if (mode_q == rwl_pkg::MODE_UPGRADE) begin
							rsp.wake_kind = rwl_pkg::WAKE_ONE;
							rsp.wake_id   = hid_q;
						end else begin
							rsp.wake_kind = rwl_pkg::WAKE_ALL;
						end
						mode_d = rwl_pkg::MODE_FREE;
						hid_d  = '0;
						hrt_d  = '0;
					end
				end
			end
			default: begin
				rsp.status = rwl_pkg::ST_ERROR;
			end
		endcase
		cnt_ext = {{rwl_pkg::CNT_W{1'b0}}, cnt_d};
		rsp.lock_state_now = mode_d;
		rsp.sharers_now    = cnt_ext[rwl_pkg::CNT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= rwl_pkg::MODE_FREE;
			cnt_q  <= '0;
			hid_q  <= '0;
			hrt_q  <= '0;
		end else if (fire) begin
			mode_q <= mode_d;
			cnt_q  <= cnt_d;
			hid_q  <= hid_d;
			hrt_q  <= hrt_d;
		end
	end

endmodule

`default_nettype wire

>>> rtl/rwl_rsp_reg.sv
// result register driving the response channel
`default_nettype none

module rwl_rsp_reg (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire rwl_pkg::rsp_t rsp_in,
	input  wire logic          in_valid,
	output logic               in_ready,
	rwl_rsp_if.source          rsp
);

	rwl_pkg::rsp_t rsp_data_s2;
	logic          rsp_valid_s2;

	assign in_ready = !rsp_valid_s2 || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_s2 <= 1'b0;
		end else if (in_ready) begin
			rsp_valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			rsp_data_s2 <= rsp_in;
		end
	end

	assign rsp.valid          = rsp_valid_s2;
	assign rsp.status         = rsp_data_s2.status;
	assign rsp.wake_kind      = rsp_data_s2.wake_kind;
	assign rsp.wake_id        = rsp_data_s2.wake_id;
	assign rsp.lock_state_now = rsp_data_s2.lock_state_now;
	assign rsp.sharers_now    = rsp_data_s2.sharers_now;

endmodule

`default_nettype wire

>>> rtl/rw_lock_upgrade_arbiter.sv
// top level of the reader-writer lock arbiter with upgrade and writer priority
//
// usage: lock requests come in on the req channel (valid/ready, one request per
// transfer: type, requester id, virtual runtime). every request yields exactly one
// result on the rsp channel: status, wake kind and id, lock mode and sharer count
// after the request.
// a request is captured in an input register, decided against the lock state by
// one compare-and-update pass, and its result is written to the output register.
// throughput is one request per cycle while the output register is empty or
// rsp.ready is high; the lock state register is the only feedback and it updates
// in the same cycle a request moves to the output.
// when rsp.ready is low the output register holds its result, the request in the
// input register waits, and req.ready drops once both registers are full; it
// returns in the cycle the result is taken.
// reset (arst_n low) empties both registers and puts the lock into free mode
// with no sharers and no recorded holder.
`default_nettype none

module rw_lock_upgrade_arbiter #(
	parameter int unsigned ID_BITS     = 8,
	parameter int unsigned MAX_SHARERS = 255
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	rwl_req_if.sink     req,
	rwl_rsp_if.source   rsp
);

	rwl_pkg::req_t req_s1;
	rwl_pkg::rsp_t core_rsp;
	logic          valid_s1;
	logic          out_ready;
	logic          fire;

	assign fire = valid_s1 && out_ready;

	rwl_req_reg u_req_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.advance  (fire),
		.req_s1   (req_s1),
		.valid_s1 (valid_s1)
	);

	rwl_lock_core #(
		.ID_BITS     (ID_BITS),
		.MAX_SHARERS (MAX_SHARERS)
	) u_lock_core (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_s1),
		.fire   (fire),
		.rsp    (core_rsp)
	);

	rwl_rsp_reg u_rsp_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.rsp_in   (core_rsp),
		.in_valid (valid_s1),
		.in_ready (out_ready),
		.rsp      (rsp)
	);

endmodule

`default_nettype wire
